// File: sv/fbfl_pkg.sv
// Package for the fixed block free-list allocator.
// Holds sizes, widths, result codes and the controller/datapath interface types.
// No dependencies.
package fbfl_pkg;

	localparam int BLOCKS_PER_CHUNK = 256;
	localparam int MAX_CHUNKS = 4;
	localparam int POINTER_BYTES = 8;
	localparam int BLOCK_BYTES_RESET = 64;

	localparam int TYPE_W = 1;
	localparam int SIZE_W = 16;
	localparam int IDX_W = 10;
	localparam int GSIZE_W = 17;
	localparam int STAT_W = 2;
	localparam int LINK_W = IDX_W + 1;
	localparam int LINK_DEPTH = 1 << IDX_W;
	localparam int FL_W = $clog2(BLOCKS_PER_CHUNK + 1);
	localparam int CC_W = $clog2(MAX_CHUNKS + 1);
	localparam int PROD_W = CC_W + FL_W;

	localparam int IN_TDATA_W = ((SIZE_W + IDX_W + 7) / 8) * 8;
	localparam int IN_TUSER_W = TYPE_W;
	localparam int OUT_TDATA_W = ((IDX_W + GSIZE_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 1 + STAT_W;

	localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b0;
	localparam logic [TYPE_W-1:0] REQ_FREE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE = 2'd0,
		STAT_BIG = 2'd1,
		STAT_EXH = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		RES_FREE,
		RES_BIG,
		RES_EXH,
		RES_FRESH,
		RES_POP
	} res_sel_t;

	typedef struct packed {
		logic push;
		logic pop_read;
		logic pop_finish;
		logic fresh_take;
		logic load_out;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic too_big;
		logic head_valid;
		logic fresh_ok;
	} dp_stat_t;

endpackage

// File: sv/fbfl_dpath.sv
// Datapath of the fixed block free-list allocator: size register, free-list head,
// link memory, chunk counters and result register. Uses fbfl_pkg.
module fbfl_dpath import fbfl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SIZE_W-1:0]      cfg_data,
	input  logic [TYPE_W-1:0]      req_type,
	input  logic [SIZE_W-1:0]      req_size,
	input  logic [IDX_W-1:0]       free_index,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	output logic [OUT_TDATA_W-1:0] out_tdata,  // block_index, granted_size, zero pad
	output logic [OUT_TUSER_W-1:0] out_tuser   // ok, status
);

	logic [SIZE_W-1:0]  block_bytes_q;
	logic [LINK_W-1:0]  free_head_q;
	logic [FL_W-1:0]    fresh_left_q;
	logic [CC_W-1:0]    chunk_count_q;
	logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
	logic [LINK_W-1:0]  rdata_q;

	logic [GSIZE_W-1:0] eff_size;
	logic               need_chunk;
	logic [FL_W-1:0]    fresh_eff;
	logic [CC_W-1:0]    chunk_eff;
	logic [PROD_W-1:0]  fresh_sum;
	logic [IDX_W-1:0]   fresh_idx;

	logic               res_ok;
	logic [IDX_W-1:0]   res_idx;
	logic [GSIZE_W-1:0] res_gsize;
	stat_t              res_stat;

	always_comb begin
		if (block_bytes_q > SIZE_W'(POINTER_BYTES)) begin
			eff_size = GSIZE_W'(block_bytes_q) + GSIZE_W'(1);
		end else begin
			eff_size = GSIZE_W'(POINTER_BYTES) + GSIZE_W'(1);
		end
	end

	assign need_chunk = (fresh_left_q == '0) && (chunk_count_q < CC_W'(MAX_CHUNKS));
	assign fresh_eff  = need_chunk ? FL_W'(BLOCKS_PER_CHUNK) : fresh_left_q;
	assign chunk_eff  = need_chunk ? chunk_count_q + CC_W'(1) : chunk_count_q;
	assign fresh_sum  = PROD_W'(chunk_eff - CC_W'(1)) * PROD_W'(BLOCKS_PER_CHUNK)
		+ PROD_W'(fresh_eff - FL_W'(1));
	assign fresh_idx  = fresh_sum[IDX_W-1:0];

	assign stat.is_free    = (req_type == REQ_FREE);
	assign stat.too_big    = (GSIZE_W'(req_size) > eff_size);
	assign stat.head_valid = free_head_q[IDX_W];
	assign stat.fresh_ok   = (fresh_eff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= SIZE_W'(BLOCK_BYTES_RESET);
			free_head_q   <= '0;
			fresh_left_q  <= FL_W'(BLOCKS_PER_CHUNK);
			chunk_count_q <= CC_W'(1);
		end else begin
			if (cfg_we) begin
				block_bytes_q <= cfg_data;
			end
			if (cmd.push) begin
				free_head_q <= {1'b1, free_index};
			end else if (cmd.pop_finish) begin
				free_head_q <= rdata_q;
			end
			if (cmd.fresh_take) begin
				fresh_left_q  <= fresh_eff - FL_W'(1);
				chunk_count_q <= chunk_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			link_mem[free_index] <= free_head_q;
		end
		if (cmd.pop_read) begin
			rdata_q <= link_mem[free_head_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		res_ok    = 1'b0;
		res_idx   = '0;
		res_gsize = '0;
		res_stat  = STAT_DONE;
		case (cmd.res_sel)
			RES_FREE: begin
				res_ok = 1'b1;
			end
			RES_BIG: begin
				res_stat = STAT_BIG;
			end
			RES_EXH: begin
				res_stat = STAT_EXH;
			end
			RES_FRESH: begin
				res_ok    = 1'b1;
				res_idx   = fresh_idx;
				res_gsize = eff_size;
			end
			RES_POP: begin
				res_ok    = 1'b1;
				res_idx   = free_head_q[IDX_W-1:0];
				res_gsize = eff_size;
			end
			default: begin
				res_stat = STAT_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_tdata <= OUT_TDATA_W'({res_gsize, res_idx});
			out_tuser <= {res_stat, res_ok};
		end
	end

endmodule

// File: sv/fbfl_ctrl.sv
// Controller of the fixed block free-list allocator: request sequencing and
// result handshake. Uses fbfl_pkg; drives fbfl_dpath through dp_cmd_t.
module fbfl_ctrl import fbfl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.res_sel = RES_FREE;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (stat.is_free) begin
						cmd.push     = 1'b1;
						cmd.load_out = 1'b1;
						cmd.res_sel  = RES_FREE;
					end else if (stat.too_big) begin
						cmd.load_out = 1'b1;
						cmd.res_sel  = RES_BIG;
					end else if (stat.head_valid) begin
						cmd.pop_read = 1'b1;
						state_nxt    = ST_POP;
					end else if (stat.fresh_ok) begin
						cmd.fresh_take = 1'b1;
						cmd.load_out   = 1'b1;
						cmd.res_sel    = RES_FRESH;
					end else begin
						cmd.load_out = 1'b1;
						cmd.res_sel  = RES_EXH;
					end
				end
			end
			ST_POP: begin
				if (out_free) begin
					cmd.pop_finish = 1'b1;
					cmd.load_out   = 1'b1;
					cmd.res_sel    = RES_POP;
					state_nxt      = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/fixed_block_free_list_allocator.sv
// Fixed block pool allocator with a LIFO free list: a free request, a rejected
// size, an exhausted pool and a fresh-chunk allocate load the result from idle;
// an allocate that pops the free list passes ST_POP, as the next link comes from
// the synchronous read port of the 1024-entry link memory before the head can move.
// There is a single result register: a new request enters only while it is empty
// or its result transfers in the same cycle, so a stalled result holds the input.
// Chunk 0 is available from reset; further chunks open on demand up to the limit.
// Top level; uses fbfl_pkg, fbfl_ctrl and fbfl_dpath.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [SIZE_W-1:0]      cfg_data,       // block_bytes
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // req_size, free_index, zero pad
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // req_type
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // block_index, granted_size, zero pad
	output logic [OUT_TUSER_W-1:0] m_axis_tuser    // ok, status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbfl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.req_type   (s_axis_tuser[TYPE_W-1:0]),
		.req_size   (s_axis_tdata[SIZE_W-1:0]),
		.free_index (s_axis_tdata[SIZE_W+IDX_W-1:SIZE_W]),
		.cmd        (cmd),
		.stat       (stat),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

	a_ready_needs_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tready)
		else $error("request taken while a result is stalled");

	a_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_FREE)
		|=> m_axis_tvalid && m_axis_tuser[0])
		else $error("free transfer gave no successful result");

	a_fail_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0]
		|-> (m_axis_tdata[IDX_W+GSIZE_W-1:IDX_W] == '0)
		&& (m_axis_tuser[STAT_W:1] != STAT_DONE))
		else $error("failed allocate carries a size or a done status");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tuser[STAT_W:1] == STAT_DONE))
		else $error("successful result with an error status");

endmodule

// File: tb/fbfl_reply_checker.sv
// Reply checker for the fixed block free-list allocator: watches the config,
// request and reply channels, keeps its own copy of the pool state, predicts each
// reply and compares it field by field. Depends on fbfl_pkg.
module fbfl_reply_checker import fbfl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [SIZE_W-1:0]      cfg_data,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
	output int                     fail_count,
	output int                     pending
);

	typedef struct {
		logic               ok;
		logic [IDX_W-1:0]   idx;
		logic [GSIZE_W-1:0] gsize;
		stat_t              status;
	} reply_t;

	logic [LINK_W-1:0] link_mem [LINK_DEPTH];
	logic [LINK_W-1:0] head;
	int                fresh_left;
	int                chunks;
	logic [SIZE_W-1:0] blk_bytes;
	reply_t            reply_q [$];
	int                printed;

	function automatic reply_t serve_request(input logic [TYPE_W-1:0] kind,
			input logic [SIZE_W-1:0] size, input logic [IDX_W-1:0] fidx);
		reply_t             r;
		logic [GSIZE_W-1:0] eff;
		r.ok = 1'b0;
		r.idx = '0;
		r.gsize = '0;
		r.status = STAT_DONE;
		eff = GSIZE_W'((blk_bytes > POINTER_BYTES) ? blk_bytes : POINTER_BYTES) + 1'b1;
		if (kind == REQ_FREE) begin
			link_mem[fidx] = head;
			head = {1'b1, fidx};
			r.ok = 1'b1;
		end else if ({1'b0, size} > eff) begin
			r.status = STAT_BIG;
		end else if (head[IDX_W]) begin
			r.idx = head[IDX_W-1:0];
			head = link_mem[r.idx];
			r.ok = 1'b1;
			r.gsize = eff;
		end else begin
			if (fresh_left == 0 && chunks < MAX_CHUNKS) begin
				chunks++;
				fresh_left = BLOCKS_PER_CHUNK;
			end
			if (fresh_left > 0) begin
				fresh_left--;
				r.idx = IDX_W'((chunks - 1) * BLOCKS_PER_CHUNK + fresh_left);
				r.ok = 1'b1;
				r.gsize = eff;
			end else begin
				r.status = STAT_EXH;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (printed < 200)
			$display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
		printed++;
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINK_DEPTH; i++)
				link_mem[i] = '0;
			head = '0;
			fresh_left = BLOCKS_PER_CHUNK;
			chunks = 1;
			blk_bytes = SIZE_W'(BLOCK_BYTES_RESET);
			reply_q.delete();
			fail_count = 0;
			printed = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				blk_bytes = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				reply_q.push_back(serve_request(s_axis_tuser[0], s_axis_tdata[SIZE_W-1:0],
					s_axis_tdata[SIZE_W +: IDX_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (reply_q.size() == 0) begin
					report_mismatch("reply with none awaited", m_axis_tdata[IDX_W-1:0], 0);
				end else begin
					want = reply_q.pop_front();
					if (m_axis_tuser[0] !== want.ok)
						report_mismatch("ok", m_axis_tuser[0], want.ok);
					if (m_axis_tuser[1 +: STAT_W] !== want.status)
						report_mismatch("status", m_axis_tuser[1 +: STAT_W], want.status);
					if (m_axis_tdata[IDX_W-1:0] !== want.idx)
						report_mismatch("block_index", m_axis_tdata[IDX_W-1:0], want.idx);
					if (m_axis_tdata[IDX_W +: GSIZE_W] !== want.gsize)
						report_mismatch("granted_size", m_axis_tdata[IDX_W +: GSIZE_W],
							want.gsize);
				end
			end
			pending <= reply_q.size();
		end
	end

endmodule

// File: tb/fixed_block_free_list_allocator_tb.sv
// Testbench top for the fixed block free-list allocator: drives config writes and
// alloc/free requests under several idle and stall patterns, and gives the verdict.
// Depends on fbfl_pkg, fixed_block_free_list_allocator and fbfl_reply_checker.
module fixed_block_free_list_allocator_tb;
	import fbfl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int FILL_ITEMS = 1024;
	localparam int RANDOM_ITEMS = 24;
	localparam int HOLD_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [SIZE_W-1:0]      cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	int               fail_count;
	int               pending;
	int               send_idle;
	int               recv_stall;
	int               hold_left;
	logic             hold_start;
	int               cycles;
	int               eff_size;
	logic [IDX_W-1:0] held [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fixed_block_free_list_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	fbfl_reply_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && m_axis_tdata[IDX_W +: GSIZE_W] != '0)
				held.push_back(m_axis_tdata[IDX_W-1:0]);
			m_axis_tready <= hold_left == 0 && $urandom_range(99) >= recv_stall;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [SIZE_W-1:0] size,
			input logic [IDX_W-1:0] fidx);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({fidx, size});
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic set_block_bytes(input logic [SIZE_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		eff_size = ((v > POINTER_BYTES) ? int'(v) : POINTER_BYTES) + 1;
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		int top_fit;
		r = $urandom_range(99);
		top_fit = (eff_size > 65535) ? 65535 : eff_size;
		if (r < 65)
			return SIZE_W'($urandom_range(top_fit));
		else if (r < 75)
			return SIZE_W'(top_fit);
		else if (r < 88 && eff_size < 65535)
			return SIZE_W'($urandom_range(65535, eff_size + 1));
		return SIZE_W'($urandom);
	endfunction

	initial begin
		int               k;
		logic [IDX_W-1:0] fidx;
		logic [SIZE_W-1:0] phase_bytes [3];
		int               idle_tab [4];
		int               stall_tab [4];
		phase_bytes = '{16'd200, 16'd8, 16'hFFFF};
		idle_tab = '{0, 75, 0, 12};
		stall_tab = '{0, 0, 75, 12};
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		hold_start <= 1'b0;
		send_idle = 0;
		recv_stall = 0;
		eff_size = BLOCK_BYTES_RESET + 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_req(REQ_ALLOC, '0, '1);
		send_req(REQ_ALLOC, SIZE_W'(eff_size), '0);
		send_req(REQ_ALLOC, SIZE_W'(eff_size + 1), '0);
		send_req(REQ_ALLOC, '1, '0);
		send_req(REQ_FREE, '1, '1);
		send_req(REQ_FREE, '0, '0);
		send_req(REQ_ALLOC, 16'd1, '0);
		send_req(REQ_ALLOC, 16'd1, '0);
		send_req(REQ_ALLOC, 16'd1, '0);
		set_block_bytes(16'd8);
		send_req(REQ_ALLOC, 16'd9, '0);
		send_req(REQ_ALLOC, 16'd10, '0);
		set_block_bytes(16'd1);
		send_req(REQ_ALLOC, 16'd9, '0);
		set_block_bytes(16'd9);
		send_req(REQ_ALLOC, 16'd10, '0);
		send_req(REQ_ALLOC, 16'd11, '0);
		set_block_bytes(16'hFFFF);
		send_req(REQ_ALLOC, 16'hFFFF, '0);

		// drain the whole pool while the reply side holds off at first
		set_block_bytes(16'd64);
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int n = 0; n < FILL_ITEMS; n++)
			send_req(REQ_ALLOC, SIZE_W'($urandom_range(eff_size)), IDX_W'($urandom));

		// double free links the list into a loop
		send_req(REQ_FREE, '0, 10'd700);
		send_req(REQ_FREE, '0, 10'd700);
		send_req(REQ_ALLOC, 16'd1, '0);
		send_req(REQ_ALLOC, 16'd1, '0);
		send_req(REQ_ALLOC, 16'd1, '0);

		for (int p = 0; p < 4; p++) begin
			set_block_bytes((p == 3) ? SIZE_W'($urandom_range(65535, 1)) : phase_bytes[p]);
			send_idle = idle_tab[p];
			recv_stall = stall_tab[p];
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if ($urandom_range(99) < 35) begin
					if (held.size() != 0 && $urandom_range(99) < 75) begin
						k = $urandom_range(held.size() - 1);
						fidx = held[k];
						held.delete(k);
					end else begin
						fidx = IDX_W'($urandom);
					end
					send_req(REQ_FREE, SIZE_W'($urandom), fidx);
				end else begin
					send_req(REQ_ALLOC, pick_size(), IDX_W'($urandom));
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
